### rtl/yuyv2rgb_pkg.sv
// yuyv2rgb_pkg: types, widths and helper functions for the yuyv to rgb converter
// no dependencies; imported by yuyv2rgb_convert, yuyv_fixed_point_to_rgb and tb

package yuyv2rgb_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 80;

  // scale factors for the color differences, applied as x*k/256 with floor
  localparam logic signed [15:0] K_RED_V   = 16'sd103;
  localparam logic signed [15:0] K_GREEN_U = 16'sd88;
  localparam logic signed [15:0] K_GREEN_V = 16'sd183;
  localparam logic signed [15:0] K_BLUE_U  = 16'sd198;

  typedef struct packed {
    logic [7:0] chroma_red;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] luma_first;
  } macropixel_t;

  typedef struct packed {
    logic [15:0] packed_second;
    logic [15:0] packed_first;
    logic [7:0]  blue_second;
    logic [7:0]  green_second;
    logic [7:0]  red_second;
    logic [7:0]  blue_first;
    logic [7:0]  green_first;
    logic [7:0]  red_first;
  } pixel_pair_t;

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 11'sd0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

### rtl/yuyv2rgb_convert.sv
// yuyv2rgb_convert: combinational color math for one macropixel
// uses yuyv2rgb_pkg (clamp8, pack565, scale factors)

module yuyv2rgb_convert (
  input  yuyv2rgb_pkg::macropixel_t mp,
  output yuyv2rgb_pkg::pixel_pair_t px
);
  import yuyv2rgb_pkg::*;

  logic signed [7:0]  u;
  logic signed [7:0]  v;
  logic signed [15:0] u_ext;
  logic signed [15:0] v_ext;
  logic signed [15:0] prod_rv;
  logic signed [15:0] prod_gu;
  logic signed [15:0] prod_gv;
  logic signed [15:0] prod_bu;
  logic signed [7:0]  q_rv;
  logic signed [7:0]  q_gu;
  logic signed [7:0]  q_gv;
  logic signed [7:0]  q_bu;
  logic signed [9:0]  rdif;
  logic signed [9:0]  gdif;
  logic signed [9:0]  bdif;
  logic signed [10:0] y0;
  logic signed [10:0] y1;
  logic [7:0]         r0, g0, b0, r1, g1, b1;

  // offset-128 chroma is the msb flipped
  assign u = {~mp.chroma_blue[7], mp.chroma_blue[6:0]};
  assign v = {~mp.chroma_red[7], mp.chroma_red[6:0]};
  assign u_ext = 16'(u);
  assign v_ext = 16'(v);

  assign prod_rv = v_ext * K_RED_V;
  assign prod_gu = u_ext * K_GREEN_U;
  assign prod_gv = v_ext * K_GREEN_V;
  assign prod_bu = u_ext * K_BLUE_U;

  // floor divide by 256
  assign q_rv = prod_rv[15:8];
  assign q_gu = prod_gu[15:8];
  assign q_gv = prod_gv[15:8];
  assign q_bu = prod_bu[15:8];

  assign rdif = 10'(v) + 10'(q_rv);
  assign gdif = 10'(q_gu) + 10'(q_gv);
  assign bdif = 10'(u) + 10'(q_bu);

  assign y0 = signed'({3'b000, mp.luma_first});
  assign y1 = signed'({3'b000, mp.luma_second});

  assign r0 = clamp8(y0 + 11'(rdif));
  assign g0 = clamp8(y0 - 11'(gdif));
  assign b0 = clamp8(y0 + 11'(bdif));
  assign r1 = clamp8(y1 + 11'(rdif));
  assign g1 = clamp8(y1 - 11'(gdif));
  assign b1 = clamp8(y1 + 11'(bdif));

  assign px.red_first     = r0;
  assign px.green_first   = g0;
  assign px.blue_first    = b0;
  assign px.red_second    = r1;
  assign px.green_second  = g1;
  assign px.blue_second   = b1;
  assign px.packed_first  = pack565(r0, g0, b0);
  assign px.packed_second = pack565(r1, g1, b1);

endmodule

### rtl/yuyv_fixed_point_to_rgb.sv
// yuyv_fixed_point_to_rgb: yuyv 4:2:2 macropixel stream to rgb888 and rgb565 pixel pairs
// uses yuyv2rgb_pkg and yuyv2rgb_convert
//
// usage:
//   input channel in_*: one yuyv macropixel per word, tlast marks the frame end
//   output channel out_*: two rgb888 pixels sharing the chroma plus their rgb565
//   forms per word, tlast copied from the input word
// path: an accepted word is held in the input register, then goes through the color
//   math into the result register, which drives out_tvalid
// throughput: one word per cycle while out_tready is high, set by the two-register pipeline
//   with no iteration; every stage advances when the stage after it is empty or draining
// reset: rst_n low empties both stages, out_tvalid and internal valids go low
// stall: with out_tready low the result word holds, the input register fills
//   behind it, and in_tready then drops until out_tready returns

module yuyv_fixed_point_to_rgb (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // luma_first, chroma_blue, luma_second, chroma_red
  input  logic [yuyv2rgb_pkg::IN_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // red_first, green_first, blue_first, red_second, green_second, blue_second,
  // packed_first, packed_second
  output logic [yuyv2rgb_pkg::OUT_W-1:0]  out_tdata,
  output logic                            out_tlast
);
  import yuyv2rgb_pkg::*;

  logic        in_valid_r;
  logic        in_valid_nxt;
  macropixel_t in_data_r;
  logic        in_last_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  pixel_pair_t out_data_r;
  logic        out_last_r;
  pixel_pair_t px;
  logic        out_free;
  logic        advance;
  logic        in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_fire || (in_valid_r && !out_free);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  yuyv2rgb_convert u_convert (
    .mp (in_data_r),
    .px (px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= macropixel_t'(in_tdata);
      in_last_r <= in_tlast;
    end
    if (advance) begin
      out_data_r <= px;
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tlast  = out_last_r;

  a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted word not held in input register");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(in_data_r) && $stable(in_last_r))
    else $error("input register changed while result stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded on advance");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_tready))
    else $error("result dropped without handshake");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

endmodule

### sim/tb.sv
// tb: self-checking testbench for yuyv_fixed_point_to_rgb, yuyv macropixels in, rgb pairs out
// depends on yuyv2rgb_pkg and the yuyv_fixed_point_to_rgb rtl; predicts every word in-line
`timescale 1ns / 1ps

module tb;
  import yuyv2rgb_pkg::*;

  localparam int CHROMA_OFFSET = 128;
  localparam time RUN_LIMIT    = 10ms;

  typedef struct {
    pixel_pair_t pixels;
    logic        frame_end;
  } expected_word_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;

  expected_word_t      pending_words[$];
  int                  error_count   = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  hold_cycles   = 0;

  yuyv_fixed_point_to_rgb DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[yuyv_fixed_point_to_rgb] ERROR");
    $finish;
  end

  function automatic logic [7:0] saturate_channel(input int x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic pixel_pair_t predict_pixel_pair(input macropixel_t mp);
    int          u;
    int          v;
    int          rdif;
    int          gdif;
    int          bdif;
    pixel_pair_t pp;
    u    = int'(mp.chroma_blue) - CHROMA_OFFSET;
    v    = int'(mp.chroma_red) - CHROMA_OFFSET;
    // floor scaling by 1/256 through arithmetic shift
    rdif = v + ((v * int'(K_RED_V)) >>> 8);
    gdif = ((u * int'(K_GREEN_U)) >>> 8) + ((v * int'(K_GREEN_V)) >>> 8);
    bdif = u + ((u * int'(K_BLUE_U)) >>> 8);
    pp.red_first     = saturate_channel(int'(mp.luma_first) + rdif);
    pp.green_first   = saturate_channel(int'(mp.luma_first) - gdif);
    pp.blue_first    = saturate_channel(int'(mp.luma_first) + bdif);
    pp.red_second    = saturate_channel(int'(mp.luma_second) + rdif);
    pp.green_second  = saturate_channel(int'(mp.luma_second) - gdif);
    pp.blue_second   = saturate_channel(int'(mp.luma_second) + bdif);
    pp.packed_first  = {pp.red_first[7:3], pp.green_first[7:2], pp.blue_first[7:3]};
    pp.packed_second = {pp.red_second[7:3], pp.green_second[7:2], pp.blue_second[7:3]};
    return pp;
  endfunction

  // sender: called and returns at a falling edge
  task automatic send_macropixel(input macropixel_t mp, input logic frame_end);
    expected_word_t exp_word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= mp;
    in_tlast  <= frame_end;
    do begin
      @(posedge clk);
    end while (!in_tready);
    exp_word.pixels    = predict_pixel_pair(mp);
    exp_word.frame_end = frame_end;
    pending_words.push_back(exp_word);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input int unsigned expected_val,
                             input int unsigned actual_val);
    if (expected_val != actual_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected_val, actual_val);
      error_count++;
    end
  endtask

  // receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    expected_word_t exp_word;
    pixel_pair_t    act;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("output word with no expected word pending");
        error_count++;
      end else begin
        exp_word = pending_words.pop_front();
        act      = out_tdata;
        check_field("red_first", 32'(exp_word.pixels.red_first), 32'(act.red_first));
        check_field("green_first", 32'(exp_word.pixels.green_first),
                    32'(act.green_first));
        check_field("blue_first", 32'(exp_word.pixels.blue_first), 32'(act.blue_first));
        check_field("red_second", 32'(exp_word.pixels.red_second), 32'(act.red_second));
        check_field("green_second", 32'(exp_word.pixels.green_second),
                    32'(act.green_second));
        check_field("blue_second", 32'(exp_word.pixels.blue_second),
                    32'(act.blue_second));
        check_field("packed_first", 32'(exp_word.pixels.packed_first),
                    32'(act.packed_first));
        check_field("packed_second", 32'(exp_word.pixels.packed_second),
                    32'(act.packed_second));
        check_field("frame_end_out", 32'(exp_word.frame_end), 32'(out_tlast));
      end
    end
  end

  function automatic macropixel_t build_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                                   input logic [7:0] y1, input logic [7:0] v);
    macropixel_t mp;
    mp.luma_first  = y0;
    mp.chroma_blue = u;
    mp.luma_second = y1;
    mp.chroma_red  = v;
    return mp;
  endfunction

  // chroma extremes and center against both luma extremes, so every channel clamps both ways
  task automatic test_extremes();
    logic [7:0] chroma_vals[3];
    chroma_vals = '{8'd0, 8'd128, 8'd255};
    foreach (chroma_vals[i]) begin
      foreach (chroma_vals[j]) begin
        send_macropixel(build_macropixel(8'd0, chroma_vals[i], 8'd255, chroma_vals[j]),
                        1'((i + j) % 2));
      end
    end
    send_macropixel(build_macropixel(8'd255, 8'd0, 8'd0, 8'd255), 1'b0);
    send_macropixel(build_macropixel(8'd255, 8'd255, 8'd0, 8'd0), 1'b1);
    send_macropixel(build_macropixel(8'd128, 8'd127, 8'd127, 8'd129), 1'b0);
    send_macropixel(build_macropixel(8'd127, 8'd129, 8'd128, 8'd127), 1'b1);
    send_macropixel(build_macropixel(8'd1, 8'd1, 8'd254, 8'd254), 1'b0);
    send_macropixel(build_macropixel(8'd16, 8'd128, 8'd235, 8'd128), 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_stream(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      send_macropixel(macropixel_t'($urandom), ($urandom_range(15) == 0));
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 200;
    repeat (40) begin
      send_macropixel(macropixel_t'($urandom), ($urandom_range(7) == 0));
    end
  endtask

  // sender pauses until every word has come out, then resumes
  task automatic test_drain_pause();
    test_random_stream(30, 0, 50);
    wait_for_drain();
    test_random_stream(30, 0, 50);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_random_stream(400, 0, 0);
    test_random_stream(380, 82, 0);
    test_random_stream(380, 0, 82);
    test_random_stream(380, 23, 23);
    test_backpressure();
    test_drain_pause();

    stall_pct = 0;
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("[yuyv_fixed_point_to_rgb] OK");
    end else begin
      $display("[yuyv_fixed_point_to_rgb] ERROR");
    end
    $finish;
  end

endmodule
